// ===== hdl/dad_pkg.sv =====
// Shared types, constants and the month-length calendar function for the date adder.
package dad_pkg;

    localparam int DAY_COUNT_BITS = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int CENT_W  = 8;
    localparam int REM_W   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd16383;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
    localparam logic [REM_W-1:0]   CENT_LAST    = 7'd99;

    // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
    localparam int unsigned RECIP_100 = 5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W = 27;

    typedef struct packed {
        logic                      fits;
        logic                      at_end;
        logic [DAY_W-1:0]          len;
        logic [DAY_W-1:0]          day_sum;
        logic [DAY_COUNT_BITS-1:0] left_next;
    } step_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? FEB_LEAP_LEN : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/dad_year_split.sv =====
// Splits a year into hundreds and remainder with a registered reciprocal multiply.
module dad_year_split (
    input  logic                          aclk,
    input  logic [dad_pkg::YEAR_W-1:0]    year,
    output logic [dad_pkg::CENT_W-1:0]    cent,
    output logic [dad_pkg::REM_W-1:0]     rem
);

    logic [dad_pkg::PROD_W-1:0] prod_reg;
    logic [dad_pkg::YEAR_W-1:0] year_reg;
    logic [15:0]                cent_x100;

    always_ff @(posedge aclk) begin
        prod_reg <= dad_pkg::PROD_W'(year) * dad_pkg::PROD_W'(dad_pkg::RECIP_100);
        year_reg <= year;
    end

    assign cent      = prod_reg[dad_pkg::RECIP_SHIFT +: dad_pkg::CENT_W];
    assign cent_x100 = 16'(cent) * 16'd100;
    assign rem       = dad_pkg::REM_W'(year_reg - cent_x100[dad_pkg::YEAR_W-1:0]);

endmodule

// ===== hdl/dad_month_unit.sv =====
// Shared month step unit: month length, room left in the month and the remaining count.
module dad_month_unit (
    input  logic [dad_pkg::DAY_W-1:0]          day,
    input  logic [dad_pkg::MONTH_W-1:0]        month,
    input  logic [dad_pkg::YEAR_W-1:0]         year,
    input  logic                               leap,
    input  logic [dad_pkg::DAY_COUNT_BITS-1:0] left,
    output dad_pkg::step_t                     step
);

    logic [dad_pkg::DAY_W-1:0]          len;
    logic [dad_pkg::DAY_W-1:0]          room;
    logic [dad_pkg::DAY_COUNT_BITS-1:0] room_ext;

    assign len      = dad_pkg::month_days(month, leap);
    assign room     = len - day;
    assign room_ext = dad_pkg::DAY_COUNT_BITS'(room);

    always_comb begin
        step.len       = len;
        step.fits      = (left <= room_ext);
        step.at_end    = (month == dad_pkg::MONTH_DEC) && (year == dad_pkg::YEAR_MAX);
        step.day_sum   = day + dad_pkg::DAY_W'(left);
        step.left_next = left - room_ext - dad_pkg::DAY_COUNT_BITS'(1);
    end

endmodule

// ===== hdl/gregorian_date_add_days_core.sv =====
// Top level of the Gregorian date adder: sequencer, date registers and stream ports.
//
// Channel   Dir  Fields (lowest bit up)                             Handshake
// s_        in   tdata: start_day, start_month, start_year,         s_tvalid/s_tready
//                       day_count
// m_        out  tdata: end_day, end_month, end_year;               m_tvalid/m_tready
//                tuser: start_valid
//
// A result steps through LOAD, SPLIT and CHECK after the accepting edge; RUN then crosses one month
// at a time with the shared month unit and takes a last step when the count ends inside a month or
// saturates. The input is not ready again until the sequencer has written the result and is idle.
// Reset clears the sequencer and the result valid; date registers are not reset.
// A finished result waits in the output register; a new input is taken meanwhile,
// and its result holds in the sequencer until the output register frees.
module gregorian_date_add_days_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // start_day, start_month, start_year, day_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // end_day, end_month, end_year
    output logic [0:0]  m_tuser   // start_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SPLIT,
        ST_CHECK,
        ST_RUN
    } state_t;

    state_t                              state_reg, state_next;
    logic [dad_pkg::DAY_W-1:0]           day_reg, day_next;
    logic [dad_pkg::MONTH_W-1:0]         month_reg, month_next;
    logic [dad_pkg::YEAR_W-1:0]          year_reg, year_next;
    logic [dad_pkg::DAY_COUNT_BITS-1:0]  left_reg, left_next;
    logic [dad_pkg::CENT_W-1:0]          cent_reg, cent_next;
    logic [dad_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic                                ok_reg, ok_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [23:0]                         m_tdata_reg, m_tdata_next;
    logic                                m_tuser_reg, m_tuser_next;

    logic [dad_pkg::CENT_W-1:0]          split_cent;
    logic [dad_pkg::REM_W-1:0]           split_rem;
    logic                                leap;
    logic [dad_pkg::DAY_W-1:0]           cur_len;
    dad_pkg::step_t                      step;
    logic                                out_free;
    logic                                accept_in;

    dad_year_split u_split (
        .aclk (aclk),
        .year (year_reg),
        .cent (split_cent),
        .rem  (split_rem)
    );

    dad_month_unit u_month (
        .day   (day_reg),
        .month (month_reg),
        .year  (year_reg),
        .leap  (leap),
        .left  (left_reg),
        .step  (step)
    );

    assign leap = ((year_reg[1:0] == 2'd0) && (rem_reg != '0)) ||
                  ((rem_reg == '0) && (cent_reg[1:0] == 2'd0));
    assign cur_len   = dad_pkg::month_days(month_reg, leap);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign accept_in = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        left_next     = left_reg;
        cent_next     = cent_reg;
        rem_next      = rem_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    day_next   = s_tdata[4:0];
                    month_next = s_tdata[8:5];
                    year_next  = s_tdata[22:9];
                    left_next  = dad_pkg::DAY_COUNT_BITS'(s_tdata[38:23]);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                cent_next  = split_cent;
                rem_next   = split_rem;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                ok_next = (year_reg != '0) && (day_reg != '0) && (day_reg <= cur_len);
                if (!((year_reg != '0) && (day_reg != '0) && (day_reg <= cur_len))) begin
                    left_next = '0;
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (left_reg == '0) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {1'b0, year_reg, month_reg, day_reg};
                        m_tuser_next  = ok_reg;
                        state_next    = ST_IDLE;
                    end
                end else if (step.fits) begin
                    day_next  = step.day_sum;
                    left_next = '0;
                end else if (step.at_end) begin
                    day_next  = step.len;
                    left_next = '0;
                end else begin
                    left_next = step.left_next;
                    day_next  = dad_pkg::DAY_W'(1);
                    if (month_reg == dad_pkg::MONTH_DEC) begin
                        month_next = dad_pkg::MONTH_JAN;
                        year_next  = year_reg + dad_pkg::YEAR_W'(1);
                        if (rem_reg == dad_pkg::CENT_LAST) begin
                            rem_next  = '0;
                            cent_next = cent_reg + dad_pkg::CENT_W'(1);
                        end else begin
                            rem_next = rem_reg + dad_pkg::REM_W'(1);
                        end
                    end else begin
                        month_next = month_reg + dad_pkg::MONTH_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        day_reg     <= day_next;
        month_reg   <= month_next;
        year_reg    <= year_next;
        left_reg    <= left_next;
        cent_reg    <= cent_next;
        rem_reg     <= rem_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in |=> !s_tready)
        else $error("input taken while sequencer busy");

    a_count_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && $past(state_reg == ST_RUN) |-> left_reg <= $past(left_reg))
        else $error("remaining day count grew");

    a_valid_month_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && ok_reg |->
            (month_reg >= dad_pkg::MONTH_JAN) && (month_reg <= dad_pkg::MONTH_DEC) &&
            (day_reg != '0) && (day_reg <= cur_len))
        else $error("date left the calendar while advancing");

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> rem_reg <= dad_pkg::CENT_LAST)
        else $error("year remainder out of range");

endmodule
